// ----- rtl/core/htfl_pkg.sv -----
// Shared types and constants for the handle table with free list.
package htfl_pkg;

	// Table geometry
	localparam int TABLE_DEPTH = 1024;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int LINK_W      = IDX_W + 1;
	localparam logic [LINK_W-1:0] LIST_EMPTY = '1;
	localparam logic [LINK_W-1:0] DEPTH_LINK = LINK_W'(TABLE_DEPTH);

	// Field widths fixed by the transaction format
	localparam int HANDLE_W = 10;
	localparam int TAG_W    = 32;
	localparam int REFS_W   = 16;
	localparam int OPEN_W   = 11;
	localparam logic [REFS_W-1:0] REFS_MAX = '1;

	// Queue between front and back
	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	typedef enum logic [1:0] {
		CMD_ALLOC = 2'd0,
		CMD_GET   = 2'd1,
		CMD_PUT   = 2'd2,
		CMD_CLOSE = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_FULL = 2'd1,
		ST_BAD  = 2'd2,
		ST_BUSY = 2'd3
	} status_t;

	typedef enum logic {
		BK_IDLE = 1'b0,
		BK_EXEC = 1'b1
	} bk_state_t;

	// Request transaction
	typedef struct packed {
		logic [1:0]          command;
		logic [HANDLE_W-1:0] handle;
		logic [TAG_W-1:0]    owner_tag;
	} req_t;

	// Response transaction
	typedef struct packed {
		logic [1:0]          status;
		logic [HANDLE_W-1:0] result_handle;
		logic [TAG_W-1:0]    result_tag;
		logic [REFS_W-1:0]   ref_count;
		logic [OPEN_W-1:0]   open_count;
	} rsp_t;

	// Classified job handed from front to back
	typedef struct packed {
		cmd_t                cmd;
		logic [HANDLE_W-1:0] handle;
		logic [TAG_W-1:0]    tag;
		logic                in_range;
	} job_t;

	// One table entry as stored in memory
	typedef struct packed {
		logic              live;
		logic [REFS_W-1:0] refs;
		logic [TAG_W-1:0]  tag;
		logic [LINK_W-1:0] next;
	} entry_t;

endpackage

// ----- rtl/core/handle_table_free_list_core.sv -----
// Top level of the handle table with free list.
//
// Requests (req_valid/req_ready/req) carry a command, a handle and an owner
// tag; every request yields exactly one response (rsp_valid/rsp_ready/rsp)
// with status, handle, tag, reference count and open count.
// The front end classifies each request and places it in a two-entry queue,
// so requests are taken while the back end is busy or a response waits.
// The back end works on one job at a time: a read of the
// addressed table word from the single-port table memory, then the
// modify-and-write cycle that also loads the response register.
// The back end takes no new job until the previous one has loaded its response.
// Reset clears the live state at once through a high-water mark: no
// clearing pass, requests are accepted as soon as reset is released.
// When the receiver stalls, the response holds; the back end waits in its
// write cycle and the queue fills, after which req_ready drops.
module handle_table_free_list_core import htfl_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	logic q_full;
	logic push;
	job_t push_job;
	logic q_valid;
	logic q_pop;
	job_t q_head;

	htfl_front u_front (
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.q_full    (q_full),
		.push      (push),
		.job       (push_job)
	);

	htfl_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (q_full),
		.pop      (q_pop),
		.valid    (q_valid),
		.head     (q_head)
	);

	htfl_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (q_valid),
		.job       (q_head),
		.job_pop   (q_pop),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule

// ----- rtl/core/htfl_front.sv -----
// Front end: accepts request transactions and classifies them into jobs.
module htfl_front import htfl_pkg::*; (
	input  logic  req_valid,
	output logic  req_ready,
	input  req_t  req,
	input  logic  q_full,
	output logic  push,
	output job_t  job
);

	// Accept whenever the job queue has room
	assign req_ready = !q_full;
	assign push      = req_valid && !q_full;

	// Decode command and check the handle against the table size
	always_comb begin
		job.cmd      = cmd_t'(req.command);
		job.handle   = req.handle;
		job.tag      = req.owner_tag;
		job.in_range = (32'(req.handle) < 32'(TABLE_DEPTH));
	end

endmodule

// ----- rtl/core/htfl_queue.sv -----
// Short job queue between the front end and the execution back end.
module htfl_queue import htfl_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	output logic full,
	input  logic pop,
	output logic valid,
	output job_t head
);

	job_t               slot_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [Q_CNT_W-1:0] cnt_q;
	logic               do_push;
	logic               do_pop;

	assign full    = (cnt_q == Q_CNT_W'(Q_DEPTH));
	assign valid   = (cnt_q != '0);
	assign head    = slot_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && valid;

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Payload slots
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

endmodule

// ----- rtl/core/htfl_back.sv -----
// Back end: table memory, free list and read-modify-write execution of jobs.
module htfl_back import htfl_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic job_valid,
	input  job_t job,
	output logic job_pop,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	// Table memory, one word per handle
	entry_t mem [TABLE_DEPTH];

	bk_state_t         state_q, state_d;
	logic [LINK_W-1:0] free_head_q, free_head_d;
	logic [LINK_W-1:0] open_total_q, open_total_d;
	logic [LINK_W-1:0] hwm_q, hwm_d;
	logic              rsp_valid_q;
	rsp_t              rsp_q, rsp_d;
	job_t              job_s2;
	entry_t            rd_s2;

	logic              rd_en;
	logic [IDX_W-1:0]  rd_addr;
	logic              wr_en;
	logic [IDX_W-1:0]  wr_addr;
	entry_t            wr_word;
	logic              fire;

	logic              head_has;
	logic              next_has;
	logic [IDX_W-1:0]  idx;
	logic              live_h;
	logic [REFS_W-1:0] refs_n;

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// State register and architectural registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= BK_IDLE;
			free_head_q  <= LIST_EMPTY;
			open_total_q <= '0;
			hwm_q        <= '0;
			rsp_valid_q  <= 1'b0;
		end else begin
			state_q      <= state_d;
			free_head_q  <= free_head_d;
			open_total_q <= open_total_d;
			hwm_q        <= hwm_d;
			if (fire) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Job and response payload
	always_ff @(posedge clk) begin
		if (job_pop) begin
			job_s2 <= job;
		end
		if (fire) begin
			rsp_q <= rsp_d;
		end
	end

	// Memory ports: registered read, single write
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_s2 <= mem[rd_addr];
		end
		if (wr_en) begin
			mem[wr_addr] <= wr_word;
		end
	end

	// Next state, memory control and result
	always_comb begin
		state_d      = state_q;
		free_head_d  = free_head_q;
		open_total_d = open_total_q;
		hwm_d        = hwm_q;
		job_pop      = 1'b0;
		rd_en        = 1'b0;
		rd_addr      = IDX_W'(job.handle);
		wr_en        = 1'b0;
		wr_addr      = '0;
		wr_word      = rd_s2;
		fire         = 1'b0;
		rsp_d        = '0;
		head_has     = (free_head_q < DEPTH_LINK);
		next_has     = (rd_s2.next < DEPTH_LINK);
		idx          = IDX_W'(job_s2.handle);
		// entries at or above the high-water mark were never written
		live_h       = rd_s2.live && (hwm_q > {1'b0, idx});
		refs_n       = rd_s2.refs;

		case (state_q)
			BK_IDLE: begin
				if (job_valid) begin
					job_pop = 1'b1;
					rd_en   = 1'b1;
					if (job.cmd == CMD_ALLOC) begin
						rd_addr = head_has ? free_head_q[IDX_W-1:0]
						                   : open_total_q[IDX_W-1:0];
					end
					state_d = BK_EXEC;
				end
			end

			BK_EXEC: begin
				fire = !rsp_valid_q || rsp_ready;
				rsp_d.result_handle = job_s2.handle;
				rsp_d.open_count    = OPEN_W'(open_total_q);
				if (job_s2.cmd == CMD_ALLOC) begin
					wr_word.live = 1'b1;
					wr_word.refs = '0;
					wr_word.tag  = job_s2.tag;
					if (head_has) begin
						// pop the most recently freed handle
						wr_en       = fire;
						wr_addr     = free_head_q[IDX_W-1:0];
						free_head_d = next_has ? rd_s2.next : LIST_EMPTY;
						open_total_d = open_total_q + 1'b1;
						rsp_d.status        = ST_OK;
						rsp_d.result_handle = HANDLE_W'(free_head_q[IDX_W-1:0]);
						rsp_d.open_count    = OPEN_W'(open_total_q + 1'b1);
					end else if (open_total_q < DEPTH_LINK) begin
						// first use of a handle: raise the high-water mark
						wr_en        = fire;
						wr_addr      = open_total_q[IDX_W-1:0];
						wr_word.next = LIST_EMPTY;
						open_total_d = open_total_q + 1'b1;
						hwm_d        = open_total_q + 1'b1;
						rsp_d.status        = ST_OK;
						rsp_d.result_handle = HANDLE_W'(open_total_q[IDX_W-1:0]);
						rsp_d.open_count    = OPEN_W'(open_total_q + 1'b1);
					end else begin
						rsp_d.status        = ST_FULL;
						rsp_d.result_handle = '0;
					end
				end else if (!job_s2.in_range || !live_h) begin
					rsp_d.status = ST_BAD;
				end else begin
					case (job_s2.cmd)
						CMD_GET: begin
							refs_n = (rd_s2.refs == REFS_MAX) ? rd_s2.refs
							                                   : rd_s2.refs + 1'b1;
							wr_en        = fire;
							wr_addr      = idx;
							wr_word.refs = refs_n;
							rsp_d.status     = ST_OK;
							rsp_d.result_tag = rd_s2.tag;
							rsp_d.ref_count  = refs_n;
						end
						CMD_PUT: begin
							refs_n = (rd_s2.refs == '0) ? rd_s2.refs : rd_s2.refs - 1'b1;
							wr_en        = fire;
							wr_addr      = idx;
							wr_word.refs = refs_n;
							rsp_d.status    = ST_OK;
							rsp_d.ref_count = refs_n;
						end
						default: begin
							// close: free only with at most one reference
							if (rd_s2.refs <= REFS_W'(1)) begin
								wr_en        = fire;
								wr_addr      = idx;
								wr_word.live = 1'b0;
								wr_word.refs = '0;
								wr_word.next = free_head_q;
								free_head_d  = {1'b0, idx};
								open_total_d = (open_total_q != '0) ? open_total_q - 1'b1
								                                     : open_total_q;
								rsp_d.status     = ST_OK;
								rsp_d.open_count = OPEN_W'(open_total_d);
							end else begin
								rsp_d.status    = ST_BUSY;
								rsp_d.ref_count = rd_s2.refs;
							end
						end
					endcase
				end
				// hold everything until the output register frees up
				if (fire) begin
					state_d = BK_IDLE;
				end else begin
					free_head_d  = free_head_q;
					open_total_d = open_total_q;
					hwm_d        = hwm_q;
				end
			end

			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

endmodule

// ----- rtl/core/htfl_checker.sv -----
// Port-level assertions for the handle table, bound to the top level.
module htfl_checker import htfl_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input logic rsp_valid,
	input logic rsp_ready,
	input rsp_t rsp
);

	logic [2:0]        pend_q;
	logic              seen_q;
	logic [OPEN_W-1:0] last_open_q;
	logic              req_acc;
	logic              rsp_acc;

	assign req_acc = req_valid && req_ready;
	assign rsp_acc = rsp_valid && rsp_ready;

	// Track transactions in flight and the last delivered open count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q      <= '0;
			seen_q      <= 1'b0;
			last_open_q <= '0;
		end else begin
			pend_q <= pend_q + {2'b0, req_acc} - {2'b0, rsp_acc};
			if (rsp_acc) begin
				seen_q      <= 1'b1;
				last_open_q <= rsp.open_count;
			end
		end
	end

	// A stalled response holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("response changed while stalled");

	// No response without an accepted request behind it
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> pend_q != '0)
		else $error("response without request");

	// Open count moves by at most one per transaction
	a_open_step: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_acc && seen_q |-> (rsp.open_count == last_open_q) ||
			(rsp.open_count == last_open_q + 1'b1) ||
			(rsp.open_count + 1'b1 == last_open_q))
		else $error("open count jumped");

	// Nothing is presented as reset releases
	a_reset_quiet: assert property (@(posedge clk)
		$rose(arst_n) |-> !rsp_valid)
		else $error("response valid after reset");

endmodule

bind handle_table_free_list_core htfl_checker u_chk (.*);

// ----- test/tb_handle_table_free_list_core.sv -----
// Testbench for the handle table core: random and directed requests against a table mirror.
`timescale 1ns / 100ps

module tb_handle_table_free_list_core;
	import htfl_pkg::*;

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int DRAIN_CYCLES = 8;

	logic clk;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	// Mirror of the table state
	bit                tbl_live [TABLE_DEPTH];
	logic [TAG_W-1:0]  tbl_tag  [TABLE_DEPTH];
	logic [LINK_W-1:0] tbl_next [TABLE_DEPTH];
	logic [REFS_W-1:0] tbl_refs [TABLE_DEPTH];
	logic [LINK_W-1:0] tbl_free_head = LIST_EMPTY;
	logic [OPEN_W-1:0] tbl_open = '0;
	int                tbl_high = 0;	// one above the highest handle ever handed out

	rsp_t rsp_due_q[$];
	int   accepted_cnt = 0;
	int   mismatches = 0;
	int   cycle_cnt = 0;
	int   req_gap_pct = 0;
	int   rsp_stall_pct = 0;

	handle_table_free_list_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Apply one request to the mirror and build the response it should produce
	task automatic apply_table_op(input req_t r, output rsp_t o);
		logic [LINK_W-1:0] pick;
		logic [IDX_W-1:0]  h;
		bit                got;
		o = '0;
		o.status = ST_OK;
		o.result_handle = r.handle;
		h = r.handle;
		if (cmd_t'(r.command) == CMD_ALLOC) begin
			got = 1'b1;
			pick = '0;
			if (tbl_free_head < DEPTH_LINK) begin
				// reuse the most recently freed handle
				pick = tbl_free_head;
				tbl_free_head = tbl_next[pick[IDX_W-1:0]];
				if (tbl_free_head >= DEPTH_LINK)
					tbl_free_head = LIST_EMPTY;
			end else if (tbl_open < TABLE_DEPTH) begin
				pick = LINK_W'(tbl_open);
			end else begin
				got = 1'b0;
			end
			if (got) begin
				tbl_live[pick[IDX_W-1:0]] = 1'b1;
				tbl_tag[pick[IDX_W-1:0]] = r.owner_tag;
				tbl_refs[pick[IDX_W-1:0]] = '0;
				tbl_open++;
				o.result_handle = pick[IDX_W-1:0];
				if (int'(pick) + 1 > tbl_high)
					tbl_high = int'(pick) + 1;
			end else begin
				o.status = ST_FULL;
				o.result_handle = '0;
			end
		end else if (!tbl_live[h]) begin
			o.status = ST_BAD;
		end else begin
			case (cmd_t'(r.command))
				CMD_GET: begin
					if (tbl_refs[h] != REFS_MAX)
						tbl_refs[h]++;
					o.ref_count = tbl_refs[h];
					o.result_tag = tbl_tag[h];
				end
				CMD_PUT: begin
					if (tbl_refs[h] != '0)
						tbl_refs[h]--;
					o.ref_count = tbl_refs[h];
				end
				default: begin
					if (tbl_refs[h] <= 1) begin
						// push onto the free list
						tbl_live[h] = 1'b0;
						tbl_refs[h] = '0;
						tbl_next[h] = tbl_free_head;
						tbl_free_head = {1'b0, h};
						if (tbl_open != '0)
							tbl_open--;
					end else begin
						o.status = ST_BUSY;
						o.ref_count = tbl_refs[h];
					end
				end
			endcase
		end
		o.open_count = tbl_open;
	endtask

	// Present one request, wait for the handshake, record its response
	task automatic send_req(input cmd_t c, input logic [HANDLE_W-1:0] h,
			input logic [TAG_W-1:0] t, output rsp_t want);
		req_t r;
		r.command = c;
		r.handle = h;
		r.owner_tag = t;
		@(negedge clk);
		while ($urandom_range(99) < req_gap_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		do @(posedge clk); while (!req_ready);
		apply_table_op(r, want);
		rsp_due_q.push_back(want);
		accepted_cnt++;
	endtask

	// Mostly a live handle, sometimes any handle
	function automatic logic [HANDLE_W-1:0] pick_handle();
		logic [HANDLE_W-1:0] h;
		h = HANDLE_W'($urandom_range(TABLE_DEPTH - 1));
		if (tbl_high > 0 && $urandom_range(99) < 85) begin
			for (int i = 0; i < 8; i++) begin
				h = HANDLE_W'($urandom_range(tbl_high - 1));
				if (tbl_live[h])
					break;
			end
		end
		return h;
	endfunction

	function automatic void check_field(string fname, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, want, got);
		end
	endfunction

	// Receiver stalls
	always @(negedge clk)
		rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);

	// Response checker
	always @(posedge clk) begin : rsp_check
		rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (rsp_due_q.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected response, expected none, actual %0h", $time, rsp);
			end else begin
				want = rsp_due_q.pop_front();
				check_field("status", 32'(want.status), 32'(rsp.status));
				check_field("result_handle", 32'(want.result_handle),
					32'(rsp.result_handle));
				check_field("result_tag", want.result_tag, rsp.result_tag);
				check_field("ref_count", 32'(want.ref_count), 32'(rsp.ref_count));
				check_field("open_count", 32'(want.open_count), 32'(rsp.open_count));
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// Lifecycle of a few handles: count floor, busy close, bad handles, LIFO reuse
	task automatic test_directed_ops();
		rsp_t w;
		logic [HANDLE_W-1:0] h0, h1, h2;
		send_req(CMD_ALLOC, '1, 32'h0000_0000, w);
		h0 = w.result_handle;
		send_req(CMD_ALLOC, '0, 32'hFFFF_FFFF, w);
		h1 = w.result_handle;
		send_req(CMD_ALLOC, 10'h2AA, 32'hA5A5_5A5A, w);
		h2 = w.result_handle;
		send_req(CMD_GET, h1, 32'h1234_5678, w);
		send_req(CMD_GET, h1, '0, w);
		send_req(CMD_PUT, h1, '0, w);
		send_req(CMD_PUT, h0, '1, w);		// count already zero
		send_req(CMD_PUT, h0, '0, w);
		send_req(CMD_CLOSE, h1, '0, w);		// count one: frees
		send_req(CMD_GET, h1, '0, w);		// no longer open
		send_req(CMD_GET, h2, '0, w);
		send_req(CMD_GET, h2, '0, w);
		send_req(CMD_CLOSE, h2, '0, w);		// count two: busy
		send_req(CMD_PUT, h2, '0, w);
		send_req(CMD_CLOSE, h2, '0, w);
		send_req(CMD_CLOSE, h0, '0, w);
		send_req(CMD_ALLOC, '0, 32'h8000_0001, w);	// last freed comes back first
		send_req(CMD_ALLOC, '1, 32'h7FFF_FFFE, w);
		send_req(CMD_ALLOC, '0, 32'h0F0F_F0F0, w);
		send_req(CMD_ALLOC, '0, 32'hDEAD_BEEF, w);	// fresh handle
		send_req(CMD_PUT, 10'd1023, '0, w);
		send_req(CMD_CLOSE, 10'd512, '0, w);
		send_req(CMD_GET, w.result_handle, '1, w);
	endtask

	// Open/use/close sequences mixed with single random operations
	task automatic test_random_traffic(input int n);
		rsp_t w;
		int start, roll, gets, puts;
		logic [HANDLE_W-1:0] h;
		start = accepted_cnt;
		while (accepted_cnt - start < n) begin
			roll = $urandom_range(99);
			if (roll < 40) begin
				send_req(CMD_ALLOC, HANDLE_W'($urandom_range(TABLE_DEPTH - 1)), $urandom, w);
				if (w.status == ST_OK) begin
					h = w.result_handle;
					gets = $urandom_range(3);
					puts = $urandom_range(3);
					repeat (gets) send_req(CMD_GET, h, $urandom, w);
					repeat (puts) send_req(CMD_PUT, h, $urandom, w);
					send_req(CMD_CLOSE, h, $urandom, w);
				end
			end else if (roll < 55) begin
				send_req(CMD_ALLOC, HANDLE_W'($urandom_range(TABLE_DEPTH - 1)), $urandom, w);
			end else if (roll < 75) begin
				send_req(CMD_GET, pick_handle(), $urandom, w);
			end else if (roll < 88) begin
				send_req(CMD_PUT, pick_handle(), $urandom, w);
			end else begin
				send_req(CMD_CLOSE, pick_handle(), $urandom, w);
			end
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		req_gap_pct = 6;
		rsp_stall_pct = 58;
		test_directed_ops();
		test_random_traffic(170);

		req_gap_pct = 58;
		rsp_stall_pct = 6;
		test_random_traffic(170);

		req_gap_pct = 0;
		rsp_stall_pct = 0;
		test_random_traffic(160);

		@(negedge clk);
		req_valid <= 1'b0;
		while (rsp_due_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
